// File: hdl/ffba_pkg.sv
// Package for the first-fit block allocator: constants, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned MaxBlocksDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 16;
  localparam int unsigned AddrBitsDefault    = 32;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_HEAP_START = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HEAP_END   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CMP,
    S_FIT_RD,
    S_FIT_IDX,
    S_FIT_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_BUMP,
    S_FREE_PUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] user_addr;
    logic [WordW-1:0] req_bytes;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] result_addr;
    logic [StatW-1:0] status;
    logic [WordW-1:0] copy_src;
    logic [WordW-1:0] copy_len;
  } rsp_t;

endpackage

// File: hdl/ffba_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type T is a parameter.
`timescale 1ns / 1ps
interface ffba_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/first_fit_block_allocator.sv
// First-fit block allocator, top level: sequencer, block table memories, free stack.
// Depends on ffba_pkg, ffba_if and ffba_cmp.
`timescale 1ns / 1ps
// One request at a time. Allocate walks the free stack from the newest entry,
// reading each entry and then its block, and shifts the newer entries down when
// a fitting block is removed; free and reallocate of a non-null address first
// search the block table for the address, one block in use after another. The
// worst case is a reallocate that moves; a bump allocation with an empty free
// stack goes from dispatch through the empty free stack check to the bump.
// All of it is set by the single read port on each table and the one shared
// compare unit. The result is held in an output register; the next request is
// taken the cycle after the result has been handed over.
module first_fit_block_allocator #(
  parameter int unsigned MaxBlocks   = ffba_pkg::MaxBlocksDefault,
  parameter int unsigned HeaderBytes = ffba_pkg::HeaderBytesDefault,
  parameter int unsigned AddrBits    = ffba_pkg::AddrBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ffba_pkg::WordW-1:0]   cfg_data_i,
  ffba_if.sink                        req_if,
  ffba_if.source                      rsp_if
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam logic [AddrBits:0] AddrMask = {1'b0, {AddrBits{1'b1}}};
  localparam logic [AddrBits:0] HdrW = (AddrBits+1)'(HeaderBytes);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBlocks);

  state_e state_q, state_d;

  logic [WordW-1:0] heap_end_q;
  logic [AddrBits-1:0] heap_top_q;
  logic [CntW-1:0] blk_count_q, free_count_q;
  logic [MaxBlocks-1:0] is_free_q;

  logic [AddrBits-1:0] base_mem [MaxBlocks];
  logic [WordW-1:0]    bytes_mem [MaxBlocks];
  logic [IdxW-1:0]     stack_mem [MaxBlocks];

  logic [AddrBits-1:0] base_rd_q;
  logic [WordW-1:0]    bytes_rd_q;
  logic [IdxW-1:0]     stack_rd_q;

  req_t req_q;
  rsp_t rsp_q;
  logic rsp_valid_q;

  logic [CntW-1:0] ptr_q;        // scan position
  logic [IdxW-1:0] old_idx_q;    // block found for free/realloc
  logic [WordW-1:0] old_len_q;   // size of that block
  logic            moving_q;     // realloc move in progress
  logic [AddrBits-1:0] new_addr_q;

  // table port controls
  logic            tbl_rd;
  logic [IdxW-1:0] tbl_raddr;
  logic            stk_rd;
  logic [IdxW-1:0] stk_raddr;

  // shared compare unit
  logic [AddrBits:0] cmp_a, cmp_b, cmp_c;
  logic cmp_ge, cmp_eq;
  logic [AddrBits+1:0] cmp_sum;

  ffba_cmp #(.AddrBits(AddrBits)) u_cmp (
    .a_i(cmp_a), .b_i(cmp_b), .c_i(cmp_c),
    .ge_o(cmp_ge), .eq_o(cmp_eq), .sum_o(cmp_sum)
  );

  logic [AddrBits-1:0] user_of_rd;
  assign user_of_rd = AddrBits'(({1'b0, base_rd_q} + HdrW) & AddrMask);

  logic [AddrBits:0] req_addr_x, req_size_x;
  assign req_addr_x = (AddrBits+1)'(req_q.user_addr);
  assign req_size_x = (AddrBits+1)'(req_q.req_bytes);

  // compare selection per state
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    cmp_c = '0;
    case (state_q)
      S_FIND_CMP: begin
        cmp_a = {1'b0, user_of_rd};
        cmp_b = req_addr_x;
      end
      S_FIT_CMP: begin
        cmp_a = (AddrBits+1)'(bytes_rd_q);
        cmp_b = req_size_x;
      end
      S_BUMP: begin
        cmp_a = {1'b0, heap_top_q};
        cmp_c = req_size_x + HdrW;
      end
      default: ;
    endcase
  end

  logic bump_ok;
  assign bump_ok = (cmp_sum <= (AddrBits+2)'(heap_end_q)) &&
                   (cmp_sum <= (AddrBits+2)'(AddrMask));

  logic find_hit;
  assign find_hit = cmp_eq;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:
        if (req_if.valid && !rsp_valid_q) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (mode_e'(req_q.mode))
          MODE_ALLOC:
            state_d = (req_q.req_bytes != '0) ? S_FIT_RD : S_DONE;
          MODE_FREE:
            state_d = (req_q.user_addr != '0) ? S_FIND_RD : S_DONE;
          MODE_REALLOC:
            if (req_q.user_addr == '0)
              state_d = (req_q.req_bytes != '0) ? S_FIT_RD : S_DONE;
            else state_d = S_FIND_RD;
          default: state_d = S_DONE;
        endcase
      end
      S_FIND_RD:
        state_d = (ptr_q < blk_count_q) ? S_FIND_CMP : S_DONE;
      S_FIND_CMP: begin
        if (!find_hit) state_d = S_FIND_RD;
        else if (is_free_q[ptr_q[IdxW-1:0]]) state_d = S_DONE;
        else if (req_q.mode == MODE_FREE || req_q.req_bytes == '0) state_d = S_FREE_PUSH;
        else if (bytes_rd_q >= req_q.req_bytes) state_d = S_DONE;
        else state_d = S_FIT_RD;
      end
      S_FIT_RD:
        state_d = (ptr_q != '0) ? S_FIT_IDX : S_BUMP;
      S_FIT_IDX: state_d = S_FIT_CMP;
      S_FIT_CMP:
        state_d = cmp_ge ? S_SHIFT_RD : S_FIT_RD;
      S_SHIFT_RD:
        state_d = (ptr_q + 1'b1 < free_count_q) ? S_SHIFT_WR
                : (moving_q ? S_FREE_PUSH : S_DONE);
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_BUMP:
        if (blk_count_q >= MaxCnt || !bump_ok) state_d = S_DONE;
        else state_d = moving_q ? S_FREE_PUSH : S_DONE;
      S_FREE_PUSH: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    tbl_rd    = 1'b0;
    tbl_raddr = '0;
    stk_rd    = 1'b0;
    stk_raddr = '0;
    case (state_q)
      S_FIND_RD: begin
        tbl_rd    = 1'b1;
        tbl_raddr = ptr_q[IdxW-1:0];
      end
      S_FIT_RD: begin
        stk_rd    = 1'b1;
        stk_raddr = IdxW'(ptr_q - 1'b1);
      end
      S_FIT_IDX: begin
        tbl_rd    = 1'b1;
        tbl_raddr = stack_rd_q;
      end
      S_SHIFT_RD: begin
        stk_rd    = 1'b1;
        stk_raddr = IdxW'(ptr_q + 1'b1);
      end
      default: ;
    endcase
  end

  assign req_if.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_if.valid = rsp_valid_q;
  assign rsp_if.data  = rsp_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (tbl_rd) begin
      base_rd_q  <= base_mem[tbl_raddr];
      bytes_rd_q <= bytes_mem[tbl_raddr];
    end
    if (stk_rd) stack_rd_q <= stack_mem[stk_raddr];
    if (state_q == S_BUMP && blk_count_q < MaxCnt && bump_ok) begin
      base_mem[blk_count_q[IdxW-1:0]]  <= heap_top_q;
      bytes_mem[blk_count_q[IdxW-1:0]] <= req_q.req_bytes;
    end
    if (state_q == S_SHIFT_WR) stack_mem[ptr_q[IdxW-1:0]] <= stack_rd_q;
    if (state_q == S_FREE_PUSH && free_count_q < MaxCnt)
      stack_mem[free_count_q[IdxW-1:0]] <= old_idx_q;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) req_q <= req_if.data;
    if (state_q == S_FIND_CMP && find_hit) begin
      old_idx_q <= ptr_q[IdxW-1:0];
      old_len_q <= bytes_rd_q;
    end
    if (state_q == S_FIT_CMP && cmp_ge) new_addr_q <= user_of_rd;
    if (state_q == S_BUMP) new_addr_q <= AddrBits'((cmp_sum[AddrBits:0] - req_size_x) & AddrMask);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      heap_end_q   <= '1;
      heap_top_q   <= '0;
      blk_count_q  <= '0;
      free_count_q <= '0;
      is_free_q    <= '0;
      rsp_valid_q  <= 1'b0;
      ptr_q        <= '0;
      moving_q     <= 1'b0;
      rsp_q.result_addr <= '0;
      rsp_q.status      <= ST_OK;
      rsp_q.copy_src    <= '0;
      rsp_q.copy_len    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_START) begin
          if (blk_count_q == '0) heap_top_q <= AddrBits'(cfg_data_i);
        end else if (cfg_idx_i == CFG_HEAP_END) begin
          heap_end_q <= cfg_data_i;
        end
      end
      if (rsp_valid_q && rsp_if.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_DISPATCH: begin
          rsp_q.result_addr <= '0;
          rsp_q.status      <= ST_OK;
          rsp_q.copy_src    <= '0;
          rsp_q.copy_len    <= '0;
          moving_q          <= 1'b0;
          ptr_q             <= '0;
          if (req_q.mode == MODE_ALLOC ||
              (req_q.mode == MODE_REALLOC && req_q.user_addr == '0))
            ptr_q <= free_count_q;
          if (req_q.mode == MODE_NONE) rsp_q.status <= ST_OK;
        end
        S_FIND_RD:
          if (ptr_q >= blk_count_q) rsp_q.status <= ST_BAD;
        S_FIND_CMP: begin
          if (!find_hit) ptr_q <= ptr_q + 1'b1;
          else if (is_free_q[ptr_q[IdxW-1:0]]) rsp_q.status <= ST_BAD;
          else if (req_q.mode == MODE_FREE || req_q.req_bytes == '0) ;
          else if (bytes_rd_q >= req_q.req_bytes)
            rsp_q.result_addr <= req_q.user_addr;
          else begin
            moving_q <= 1'b1;
            ptr_q    <= free_count_q;
          end
        end
        S_FIT_RD:
          if (ptr_q != '0) ptr_q <= ptr_q - 1'b1;
        S_FIT_CMP:
          if (cmp_ge) is_free_q[stack_rd_q] <= 1'b0;
        S_SHIFT_RD:
          if (!(ptr_q + 1'b1 < free_count_q)) begin
            free_count_q      <= free_count_q - 1'b1;
            rsp_q.result_addr <= WordW'(new_addr_q);
            if (moving_q) begin
              rsp_q.copy_src <= req_q.user_addr;
              rsp_q.copy_len <= old_len_q;
            end
          end
        S_SHIFT_WR: ptr_q <= ptr_q + 1'b1;
        S_BUMP: begin
          if (blk_count_q >= MaxCnt) rsp_q.status <= ST_FULL;
          else if (!bump_ok) rsp_q.status <= ST_OOM;
          else begin
            blk_count_q       <= blk_count_q + 1'b1;
            heap_top_q        <= cmp_sum[AddrBits-1:0];
            rsp_q.result_addr <= WordW'(AddrBits'((cmp_a + HdrW) & AddrMask));
            if (moving_q) begin
              rsp_q.copy_src <= req_q.user_addr;
              rsp_q.copy_len <= old_len_q;
            end
          end
        end
        S_FREE_PUSH: begin
          if (free_count_q < MaxCnt) free_count_q <= free_count_q + 1'b1;
          is_free_q[old_idx_q] <= 1'b1;
        end
        S_DONE: rsp_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/ffba_cmp.sv
// Shared compare/add unit: one unsigned >= and == compare of the same operands and one sum per cycle.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_cmp #(
  parameter int unsigned AddrBits = ffba_pkg::AddrBitsDefault
) (
  input  logic [AddrBits:0] a_i,
  input  logic [AddrBits:0] b_i,
  input  logic [AddrBits:0] c_i,
  output logic              ge_o,
  output logic              eq_o,
  output logic [AddrBits+1:0] sum_o
);
  import ffba_pkg::*;

  assign ge_o  = a_i >= b_i;
  assign eq_o  = a_i == b_i;
  assign sum_o = {1'b0, a_i} + {1'b0, c_i};
endmodule

// File: hdl/ffba_checker.sv
// Port-level checker for first_fit_block_allocator, bound to the top level.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input ffba_pkg::rsp_t rsp_data
);
  import ffba_pkg::*;

  // never take a request while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

  // a failed request returns null
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result_addr == '0)
    else $error("failing status with non-null address");

  // a copy source is only reported with a granted address
  a_copy_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.copy_src != '0 |-> rsp_data.result_addr != '0)
    else $error("copy source without new block");

  // result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped or changed");
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req_if.valid), .req_ready(req_if.ready),
  .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
  .rsp_data(rsp_if.data)
);

// File: verif/tb_top.sv
// Testbench for first_fit_block_allocator: random and directed requests checked
// against an in-bench model of the block table. Depends on ffba_pkg, ffba_if and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import ffba_pkg::*;

  localparam int unsigned NBlk = MaxBlocksDefault;
  localparam int unsigned Hdr  = HeaderBytesDefault;
  localparam int unsigned Watchdog = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [WordW-1:0] cfg_data_i = '0;

  ffba_if #(.T(req_t)) req_if ();
  ffba_if #(.T(rsp_t)) rsp_if ();

  first_fit_block_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_if(req_if.sink), .rsp_if(rsp_if.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow allocator state
  logic [31:0] h_start, h_end, h_top;
  logic [31:0] b_base [NBlk];
  logic [31:0] b_len [NBlk];
  bit b_free [NBlk];
  int unsigned fstack [NBlk];
  int unsigned n_free, n_blk;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] live_addrs[$];
  bit req_accepted = 1'b0;

  function automatic int unsigned lookup(logic [31:0] a);
    for (int unsigned i = 0; i < n_blk; i++)
      if (b_base[i] + Hdr == a) return i;
    return NBlk;
  endfunction

  function automatic status_e take_block(logic [31:0] sz, output logic [31:0] ua);
    logic [32:0] top;
    int unsigned i;
    ua = '0;
    for (int k = n_free; k > 0; k--) begin
      i = fstack[k-1];
      if (b_len[i] >= sz) begin
        for (int p = k - 1; p + 1 < n_free; p++) fstack[p] = fstack[p+1];
        n_free--;
        b_free[i] = 1'b0;
        ua = b_base[i] + Hdr;
        return ST_OK;
      end
    end
    if (n_blk >= NBlk) return ST_FULL;
    top = {1'b0, h_top} + {1'b0, sz} + Hdr;
    if (top > {1'b0, h_end}) return ST_OOM;
    i = n_blk;
    n_blk++;
    b_base[i] = h_top;
    b_len[i] = sz;
    b_free[i] = 1'b0;
    h_top = top[31:0];
    ua = b_base[i] + Hdr;
    return ST_OK;
  endfunction

  function automatic status_e release_block(logic [31:0] a);
    int unsigned i;
    if (a == 0) return ST_OK;
    i = lookup(a);
    if (i >= NBlk || b_free[i]) return ST_BAD;
    if (n_free < NBlk) begin
      fstack[n_free] = i;
      n_free++;
    end
    b_free[i] = 1'b1;
    return ST_OK;
  endfunction

  function automatic rsp_t allocator_result(req_t r);
    rsp_t o;
    int unsigned i;
    logic [31:0] na;
    o = '0;
    o.status = ST_OK;
    case (mode_e'(r.mode))
      MODE_ALLOC: if (r.req_bytes != 0) o.status = take_block(r.req_bytes, o.result_addr);
      MODE_FREE: o.status = release_block(r.user_addr);
      MODE_REALLOC: begin
        if (r.user_addr == 0) begin
          if (r.req_bytes != 0) o.status = take_block(r.req_bytes, o.result_addr);
        end else if (r.req_bytes == 0) begin
          o.status = release_block(r.user_addr);
        end else begin
          i = lookup(r.user_addr);
          if (i >= NBlk || b_free[i]) o.status = ST_BAD;
          else if (b_len[i] >= r.req_bytes) o.result_addr = r.user_addr;
          else begin
            o.status = take_block(r.req_bytes, na);
            if (o.status == ST_OK) begin
              if (n_free < NBlk) begin
                fstack[n_free] = i;
                n_free++;
              end
              b_free[i] = 1'b1;
              o.result_addr = na;
              o.copy_src = r.user_addr;
              o.copy_len = b_len[i];
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void reset_shadow();
    h_start = '0;
    h_end = '1;
    h_top = '0;
    n_free = 0;
    n_blk = 0;
    live_addrs.delete();
    for (int i = 0; i < NBlk; i++) b_free[i] = 1'b0;
  endfunction

  // driver: update valid/data at the falling edge, after acceptance at the rising edge
  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_accepted) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      if (hold_off > 0) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    req_accepted <= 1'b0;
    if (rst_ni) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
      if (req_if.valid && req_if.ready) begin
        req_accepted <= 1'b1;
        expected_rsps.push_back(allocator_result(req_if.data));
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t exp_r, got;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result addr=%h status=%0d", got.result_addr, got.status);
          n_errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.result_addr !== exp_r.result_addr) begin
            $error("result_addr exp %h got %h", exp_r.result_addr, got.result_addr);
            n_errors++;
          end
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status);
            n_errors++;
          end
          if (got.copy_src !== exp_r.copy_src) begin
            $error("copy_src exp %h got %h", exp_r.copy_src, got.copy_src);
            n_errors++;
          end
          if (got.copy_len !== exp_r.copy_len) begin
            $error("copy_len exp %h got %h", exp_r.copy_len, got.copy_len);
            n_errors++;
          end
          if (exp_r.status == ST_OK && exp_r.result_addr != 0)
            live_addrs.push_back(exp_r.result_addr);
        end
      end
      if (quiet_cycles >= Watchdog) begin
        $display("first_fit_block_allocator verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_HEAP_START) begin
      h_start = val;
      if (n_blk == 0) h_top = val;
    end else begin
      h_end = val;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic req_t pick_request(int unsigned max_sz);
    req_t r;
    int unsigned sel;
    sel = $urandom_range(99);
    r.mode = MODE_ALLOC;
    r.user_addr = '0;
    r.req_bytes = $urandom_range(1, max_sz);
    if (sel < 40) begin
      r.mode = MODE_ALLOC;
    end else if (sel < 70) begin
      r.mode = MODE_FREE;
    end else if (sel < 92) begin
      r.mode = MODE_REALLOC;
    end else if (sel < 94) begin
      r.mode = MODE_NONE;
      r.user_addr = $urandom();
      r.req_bytes = $urandom();
    end
    if (r.mode == MODE_FREE || r.mode == MODE_REALLOC) begin
      if (live_addrs.size() > 0 && $urandom_range(9) < 8)
        r.user_addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
      else if ($urandom_range(1)) r.user_addr = $urandom();
      if (r.mode == MODE_REALLOC && $urandom_range(19) == 0) r.req_bytes = '0;
    end
    if (sel >= 94) r.req_bytes = $urandom();  // huge: usually out of heap
    return r;
  endfunction

  task automatic push_req(mode_e m, logic [31:0] a, logic [31:0] b);
    req_t r;
    r.mode = m;
    r.user_addr = a;
    r.req_bytes = b;
    pending_reqs.push_back(r);
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    write_reg(CFG_HEAP_START, 32'h0000_1000);
    write_reg(CFG_HEAP_END, 32'h0000_2000);
    push_req(MODE_ALLOC, 32'h0, 32'h0);            // zero size
    push_req(MODE_FREE, 32'h0, 32'h5);             // null free
    push_req(MODE_ALLOC, 32'hFFFF_FFFF, 32'd40);
    push_req(MODE_ALLOC, 32'h0, 32'd8);
    push_req(MODE_FREE, 32'h0000_1010, 32'h0);
    push_req(MODE_FREE, 32'h0000_1010, 32'h0);     // already free
    push_req(MODE_FREE, 32'hFFFF_FFFF, 32'h0);     // unknown
    push_req(MODE_ALLOC, 32'h0, 32'd20);           // reuses freed 40
    push_req(MODE_REALLOC, 32'h0000_1010, 32'd30); // fits in place
    push_req(MODE_REALLOC, 32'h0000_1010, 32'd100);// moves
    push_req(MODE_REALLOC, 32'h0, 32'd12);         // null realloc
    push_req(MODE_REALLOC, 32'h0000_1048, 32'd0);  // zero-size realloc
    push_req(MODE_REALLOC, 32'h0000_1234, 32'd4);  // unknown
    push_req(MODE_ALLOC, 32'h0, 32'hFFFF_FFFF);    // out of heap
    push_req(MODE_REALLOC, 32'h0000_1038, 32'hFFFF_FFFF); // not a user address: a block base
    push_req(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // table full: many small blocks
    write_reg(CFG_HEAP_START, 32'hFFFF_0000);      // ignored for top: blocks exist
    for (int i = 0; i < 70; i++) push_req(MODE_ALLOC, 32'h0, 32'd1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // restart the heap from reset state by freeing is impossible; keep reusing
      if (ph == 4) write_reg(CFG_HEAP_END, 32'hFFFF_FFFF);
      else if (ph == 2) write_reg(CFG_HEAP_END, 32'h0000_0000);
      for (int n = 0; n < 240; n++) begin
        pending_reqs.push_back(pick_request(ph == 3 ? 4096 : 256));
        if (ph == 0 && n == 100) begin
          while (pending_reqs.size() > 0) @(posedge clk_i);
          @(negedge clk_i);
          hold_off = 300;
        end
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end
endmodule
